// ===== src/rgb_to_xterm256_index_defines.svh =====
// ----------------------------------------------------------------------------
// RGB to xterm 256-color index: assertion macros
// Shared check macros for the pixel pipeline, clocked on rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_XTERM256_INDEX_DEFINES_SVH
`define RGB_TO_XTERM256_INDEX_DEFINES_SVH

// Same-cycle implication.
`define RGB2XT_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("rgb2xt same-cycle check failed");

// Next-cycle implication.
`define RGB2XT_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("rgb2xt next-cycle check failed");

`endif

// ===== src/rgb2xt_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to xterm 256-color index: package
// Widths, register codes, stage payload types and small lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rgb2xt_pkg;

    localparam int CHAN_W      = 8;
    localparam int IN_DATA_W   = 3 * CHAN_W;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int LEVEL_W     = 5;
    localparam int POS_W       = 5;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 12;

    localparam logic [7:0] SAT_THRESH_RESET  = 8'd64;
    localparam logic       COLOR_MODE_RESET  = 1'b1;
    localparam logic [4:0] GREY_LEVELS_RESET = 5'd26;
    localparam logic [4:0] GREY_LEVELS_MIN   = 5'd2;
    localparam logic [4:0] GREY_LEVELS_MAX   = 5'd26;

    // Grey ramp: black, 232..255, white.
    localparam logic [4:0] RAMP_LAST     = 5'd25;
    localparam logic [7:0] RAMP_BLACK    = 8'd16;
    localparam logic [7:0] RAMP_WHITE    = 8'd231;
    localparam logic [7:0] RAMP_BASE     = 8'd231;
    localparam logic [7:0] CUBE_BASE     = 8'd16;

    // Midpoints between the cube stops 00, 5f, 87, af, d7, ff.
    localparam logic [7:0] CUBE_MID0 = 8'd47;
    localparam logic [7:0] CUBE_MID1 = 8'd115;
    localparam logic [7:0] CUBE_MID2 = 8'd155;
    localparam logic [7:0] CUBE_MID3 = 8'd195;
    localparam logic [7:0] CUBE_MID4 = 8'd235;

    // BT.709 weights scaled by 2^16.
    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SAT_THRESH  = 2'd0,
        CFG_COLOR_MODE  = 2'd1,
        CFG_GREY_LEVELS = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] diff;
        logic [7:0] luma;
        logic [7:0] cube_idx;
    } front_t;

    typedef struct packed {
        logic             grey_sel;
        logic [POS_W-1:0] scaled;
        logic [7:0]       cube_idx;
    } decide_t;

    function automatic logic [2:0] cube_coord(input logic [7:0] v);
        logic [2:0] c;
        if (v < CUBE_MID0)      c = 3'd0;
        else if (v < CUBE_MID1) c = 3'd1;
        else if (v < CUBE_MID2) c = 3'd2;
        else if (v < CUBE_MID3) c = 3'd3;
        else if (v < CUBE_MID4) c = 3'd4;
        else                    c = 3'd5;
        return c;
    endfunction

    // ceil(25 * 2^12 / (levels - 1)); exact floor of scaled*25/(levels-1)
    // after the shift for every scaled below levels.
    function automatic logic [RECIP_W-1:0] grey_recip(input logic [LEVEL_W-1:0] lv);
        logic [RECIP_W-1:0] m;
        case (lv)
            5'd2:    m = 17'd102400;
            5'd3:    m = 17'd51200;
            5'd4:    m = 17'd34134;
            5'd5:    m = 17'd25600;
            5'd6:    m = 17'd20480;
            5'd7:    m = 17'd17067;
            5'd8:    m = 17'd14629;
            5'd9:    m = 17'd12800;
            5'd10:   m = 17'd11378;
            5'd11:   m = 17'd10240;
            5'd12:   m = 17'd9310;
            5'd13:   m = 17'd8534;
            5'd14:   m = 17'd7877;
            5'd15:   m = 17'd7315;
            5'd16:   m = 17'd6827;
            5'd17:   m = 17'd6400;
            5'd18:   m = 17'd6024;
            5'd19:   m = 17'd5689;
            5'd20:   m = 17'd5390;
            5'd21:   m = 17'd5120;
            5'd22:   m = 17'd4877;
            5'd23:   m = 17'd4655;
            5'd24:   m = 17'd4453;
            5'd25:   m = 17'd4267;
            5'd26:   m = 17'd4096;
            default: m = 17'd4096;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] grey_ramp(input logic [POS_W-1:0] pos);
        logic [7:0] idx;
        if (pos == '0)            idx = RAMP_BLACK;
        else if (pos >= RAMP_LAST) idx = RAMP_WHITE;
        else                      idx = RAMP_BASE + {3'b000, pos};
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== src/rgb2xt_front.sv =====
// ----------------------------------------------------------------------------
// RGB to xterm 256-color index: front stage
// Channel max/min, fixed-point luma and cube index; one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2xt_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          red,
    input  wire logic [7:0]          green,
    input  wire logic [7:0]          blue,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rgb2xt_pkg::front_t       out_data
);
    import rgb2xt_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    front_t     data_reg;
    front_t     data_next;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [23:0] luma_sum;
    logic [2:0] cr;
    logic [2:0] cg;
    logic [2:0] cb;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi)  hi = blue;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;

        // Weights sum to 2^16, so the sum fits 24 bits.
        luma_sum = 24'(red) * 24'(LUMA_WR) + 24'(green) * 24'(LUMA_WG)
                   + 24'(blue) * 24'(LUMA_WB);

        cr = cube_coord(red);
        cg = cube_coord(green);
        cb = cube_coord(blue);

        data_next.hi       = hi;
        data_next.diff     = hi - lo;
        data_next.luma     = luma_sum[23:16];
        data_next.cube_idx = CUBE_BASE + 8'(cr) * 8'd36 + 8'(cg) * 8'd6 + {5'b00000, cb};

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/rgb2xt_decide.sv =====
// ----------------------------------------------------------------------------
// RGB to xterm 256-color index: decide stage
// Saturation test by cross-multiplication and grey level scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2xt_decide (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          sat_thresh,
    input  wire logic                color_mode,
    input  wire logic [4:0]          level,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rgb2xt_pkg::front_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rgb2xt_pkg::decide_t      out_data
);
    import rgb2xt_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    decide_t     data_reg;
    decide_t     data_next;
    logic [15:0] diff_x255;
    logic [16:0] limit;
    logic [12:0] luma_x_level;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // floor(diff*255/hi) <= T  <=>  diff*255 < (T+1)*hi
        diff_x255    = {in_data.diff, 8'h00} - {8'h00, in_data.diff};
        limit        = ({1'b0, sat_thresh} + 9'd1) * in_data.hi;
        luma_x_level = in_data.luma * level;

        data_next.grey_sel = !color_mode || (in_data.hi == '0)
                             || ({1'b0, diff_x255} < limit);
        data_next.scaled   = luma_x_level[12:8];
        data_next.cube_idx = in_data.cube_idx;

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/rgb2xt_map.sv =====
// ----------------------------------------------------------------------------
// RGB to xterm 256-color index: map stage
// Grey ramp position by reciprocal multiply, final select, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2xt_map (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [4:0]          level,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rgb2xt_pkg::decide_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               palette_index
);
    import rgb2xt_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic [7:0]                 index_reg;
    logic [7:0]                 index_next;
    logic [POS_W+RECIP_W-1:0]   pos_prod;
    logic [RECIP_W-RECIP_SHIFT+POS_W-1:0] pos_wide;
    logic [POS_W-1:0]           pos;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        pos_prod = in_data.scaled * grey_recip(level);
        pos_wide = pos_prod[POS_W+RECIP_W-1:RECIP_SHIFT];
        if (pos_wide >= {{(RECIP_W-RECIP_SHIFT){1'b0}}, RAMP_LAST})
            pos = RAMP_LAST;
        else
            pos = pos_wide[POS_W-1:0];

        index_next = in_data.grey_sel ? grey_ramp(pos) : in_data.cube_idx;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            index_reg <= index_next;
        end
    end

    assign out_valid     = valid_reg;
    assign palette_index = index_reg;

endmodule

`default_nettype wire

// ===== src/rgb_to_xterm256_index.sv =====
// ----------------------------------------------------------------------------
// RGB to xterm 256-color index: top level
// Maps 8-bit RGB pixels to xterm palette indexes through a three-stage pipe.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per request: red, green, blue from the low bits.
//   m_axis returns one palette index per pixel, in order.
//   cfg writes registers: 0 saturation threshold, 1 color mode, 2 grey level
//   count (clamped to 2..26 internally); index 3 is ignored. cfg_ready is
//   always high; write only while no pixel is in flight.
// Pipeline: three register stages, front, decide and map; each pixel's
//   index reaches m_axis through them in that order.
// Throughput: one pixel per cycle while m_axis_tready is high, over stages
//   (front: max/min, luma, cube index; decide: saturation compare and grey
//   scaling; map: ramp position and output register).
// Stall: each stage holds its request while the next one is full and
//   stalled; empty stages still fill, so a stalled receiver backs up the
//   pipe one stage at a time and nothing is dropped or repeated.
// Reset: rst_n clears all valid bits and loads the register defaults
//   (threshold 64, color mode on, 26 grey levels). No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_xterm256_index_defines.svh"

module rgb_to_xterm256_index (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Pixel in: [7:0] red, [15:8] green, [23:16] blue
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [rgb2xt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Index out: [7:0] palette_index
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [rgb2xt_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // Register writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [rgb2xt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rgb2xt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rgb2xt_pkg::*;

    logic [7:0] sat_thresh_reg;
    logic [7:0] sat_thresh_next;
    logic       color_mode_reg;
    logic       color_mode_next;
    logic [4:0] grey_levels_reg;
    logic [4:0] grey_levels_next;
    logic [4:0] level;

    logic       front_valid;
    logic       front_ready;
    front_t     front_data;
    logic       dec_valid;
    logic       dec_ready;
    decide_t    dec_data;

    // Configuration registers; writes always accepted.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        sat_thresh_next  = sat_thresh_reg;
        color_mode_next  = color_mode_reg;
        grey_levels_next = grey_levels_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SAT_THRESH:  sat_thresh_next  = cfg_data;
                CFG_COLOR_MODE:  color_mode_next  = cfg_data[0];
                CFG_GREY_LEVELS: grey_levels_next = cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_thresh_reg  <= SAT_THRESH_RESET;
            color_mode_reg  <= COLOR_MODE_RESET;
            grey_levels_reg <= GREY_LEVELS_RESET;
        end
        else
        begin
            sat_thresh_reg  <= sat_thresh_next;
            color_mode_reg  <= color_mode_next;
            grey_levels_reg <= grey_levels_next;
        end
    end

    // Clamp the level count into the usable ramp range.
    always_comb
    begin
        if (grey_levels_reg < GREY_LEVELS_MIN)
            level = GREY_LEVELS_MIN;
        else if (grey_levels_reg > GREY_LEVELS_MAX)
            level = GREY_LEVELS_MAX;
        else
            level = grey_levels_reg;
    end

    rgb2xt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    rgb2xt_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .sat_thresh (sat_thresh_reg),
        .color_mode (color_mode_reg),
        .level      (level),
        .in_valid   (front_valid),
        .in_ready   (front_ready),
        .in_data    (front_data),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_data   (dec_data)
    );

    rgb2xt_map u_map (
        .clk           (clk),
        .rst_n         (rst_n),
        .level         (level),
        .in_valid      (dec_valid),
        .in_ready      (dec_ready),
        .in_data       (dec_data),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .palette_index (m_axis_tdata)
    );

    // An empty output stage means every stage can take a request.
    `RGB2XT_ASSERT_NOW(a_empty_out_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    // A ready receiver lets the whole pipe advance.
    `RGB2XT_ASSERT_NOW(a_sink_ready_prop, clk, rst_n, m_axis_tready, s_axis_tready)
    // Greyscale-only mode yields only ramp indexes.
    `RGB2XT_ASSERT_NOW(a_grey_only, clk, rst_n, m_axis_tvalid && !color_mode_reg,
        m_axis_tdata == RAMP_BLACK || m_axis_tdata == RAMP_WHITE || m_axis_tdata > RAMP_BASE)
    // Nothing appears at the output unless the stage before held a pixel.
    `RGB2XT_ASSERT_NEXT(a_no_phantom, clk, rst_n, !m_axis_tvalid && !dec_valid, !m_axis_tvalid)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_xterm256_index testbench
// Streams RGB pixels into the palette mapper under random source gaps and
// sink stalls, predicts each palette index from the current register
// settings and checks every returned index in order.
// ----------------------------------------------------------------------------
module tb;

    import rgb2xt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    // Pipe depth is three stages; leave some margin before touching registers.
    localparam int SETTLE_CYCLES = 8;

    // Cube stops, lowest in the lowest byte.
    localparam logic [5:0][7:0] CUBE_STOP =
        {8'hff, 8'hd7, 8'haf, 8'h87, 8'h5f, 8'h00};
    localparam logic [7:0] GREY_BLACK = 8'd16;
    localparam logic [7:0] GREY_WHITE = 8'd231;
    localparam logic [7:0] GREY_BASE  = 8'd231;
    localparam logic [4:0] GREY_STEPS = 5'd25;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] index;
    } palette_entry_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    // Pixel in: [7:0] red, [15:8] green, [23:16] blue
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    // Index out: [7:0] palette_index
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_SAT_THRESH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Register shadow used by the palette predictor.
    logic [7:0] sat_threshold = SAT_THRESH_RESET;
    logic       color_on      = COLOR_MODE_RESET;
    logic [4:0] grey_count    = GREY_LEVELS_RESET;

    palette_entry_t palette_fifo[$];

    int  errors      = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  tx_gaps_on  = 1'b1;
    bit  rx_stall_on = 1'b1;

    rgb_to_xterm256_index dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** rgb_to_xterm256_index: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Palette predictor
    // ------------------------------------------------------------------------

    // Cube coordinate 0..5: position of the first midpoint the value is below.
    function automatic logic [2:0] cube_level(input logic [7:0] v);
        logic [8:0] mid;
        logic [2:0] level;
        level = 3'd5;
        for (int i = 4; i >= 0; i--)
        begin
            mid = ({1'b0, CUBE_STOP[i]} + {1'b0, CUBE_STOP[i+1]}) >> 1;
            if ({1'b0, v} < mid)
                level = i[2:0];
        end
        return level;
    endfunction

    function automatic logic [7:0] predict_palette_index(input logic [7:0] red,
                                                         input logic [7:0] green,
                                                         input logic [7:0] blue);
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [15:0] spread;
        logic [7:0]  sat;
        logic [23:0] luma_acc;
        logic [7:0]  luma;
        logic [4:0]  lv;
        logic [12:0] luma_lv;
        logic [4:0]  scaled;
        logic [9:0]  pos;
        logic [7:0]  index;
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi)  hi = blue;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;
        if (hi == 8'd0)
            sat = 8'd0;
        else
        begin
            spread = (hi - lo) * 16'd255;
            sat    = spread / hi;
        end

        if (!color_on || sat <= sat_threshold)
        begin
            luma_acc = 24'd13933 * red + 24'd46871 * green + 24'd4732 * blue;
            luma     = luma_acc[23:16];
            // Clamp the level count into 2..26.
            lv = grey_count;
            if (lv < GREY_LEVELS_MIN)
                lv = GREY_LEVELS_MIN;
            else if (lv > GREY_LEVELS_MAX)
                lv = GREY_LEVELS_MAX;
            luma_lv = luma * lv;
            scaled  = luma_lv[12:8];
            pos     = (scaled * 10'd25) / (lv - 5'd1);
            if (pos == 10'd0)
                index = GREY_BLACK;
            else if (pos >= GREY_STEPS)
                index = GREY_WHITE;
            else
                index = GREY_BASE + pos[7:0];
        end
        else
            index = 8'd16 + 8'd36 * cube_level(red) + 8'd6 * cube_level(green)
                    + cube_level(blue);
        return index;
    endfunction

    // ------------------------------------------------------------------------
    // Sink side: random stall bursts on m_axis_tready
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (rx_stall_on && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 5);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted index with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        palette_entry_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (palette_fifo.size() == 0)
                report_failure($sformatf("unexpected index %0d at cycle %0d",
                                         m_axis_tdata, cycle_count));
            else
            begin
                want = palette_fifo.pop_front();
                if (m_axis_tdata !== want.index)
                    report_failure($sformatf(
                        "pixel r=%0d g=%0d b=%0d: expected index %0d, got %0d",
                        want.red, want.green, want.blue, want.index, m_axis_tdata));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Send one pixel request, optionally after a source gap, and record the
    // predicted index once it is accepted. Valid stays high on return so
    // back-to-back pixels go out at full rate.
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        palette_entry_t entry;
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        do
            @(posedge clk);
        while (!s_axis_tready);
        entry.red   = red;
        entry.green = green;
        entry.blue  = blue;
        entry.index = predict_palette_index(red, green, blue);
        palette_fifo.push_back(entry);
    endtask

    // Random pixel: half uniform, with near-grey pixels, midpoint edges
    // and channel extremes mixed in.
    task automatic send_random_pixel();
        logic [7:0] ch [3];
        logic [7:0] base;
        logic [7:0] edges [12];
        edges = '{8'd0, 8'd46, 8'd47, 8'd114, 8'd115, 8'd154,
                  8'd155, 8'd194, 8'd195, 8'd234, 8'd235, 8'd255};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                for (int i = 0; i < 3; i++)
                    ch[i] = 8'($urandom_range(0, 255));
            5, 6:
            begin
                // Close to grey so the saturation compare is exercised.
                base = 8'($urandom_range(0, 255));
                for (int i = 0; i < 3; i++)
                    ch[i] = base ^ 8'($urandom_range(0, 63) >> $urandom_range(0, 6));
            end
            7, 8:
                for (int i = 0; i < 3; i++)
                    ch[i] = edges[$urandom_range(0, 11)];
            default:
                for (int i = 0; i < 3; i++)
                    ch[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
        send_pixel(ch[0], ch[1], ch[2]);
    endtask

    // Drop valid and wait until every predicted index has come back.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (palette_fifo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register request and mirror it into the predictor shadow.
    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SAT_THRESH:  sat_threshold = value;
            CFG_COLOR_MODE:  color_on      = value[0];
            CFG_GREY_LEVELS: grey_count    = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [7:0] mode,
                              input logic [7:0] levels);
        write_reg(CFG_SAT_THRESH, thr);
        write_reg(CFG_COLOR_MODE, mode);
        write_reg(CFG_GREY_LEVELS, levels);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults: black, white, primaries, tied channels, saturation
    // right at the threshold, and each cube midpoint from both sides.
    task automatic test_reset_defaults();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd191, 8'd191);  // saturation 64: grey
        send_pixel(8'd255, 8'd190, 8'd190);  // saturation 65: cube
        send_pixel(8'd46,  8'd47,  8'd255);
        send_pixel(8'd114, 8'd115, 8'd0);
        send_pixel(8'd154, 8'd155, 8'd0);
        send_pixel(8'd194, 8'd195, 8'd0);
        send_pixel(8'd234, 8'd235, 8'd0);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'hAA,  8'h55,  8'hAA);
        send_pixel(8'h55,  8'hAA,  8'h55);
        wait_idle();
    endtask

    // Threshold extremes: 0 lets only exact greys through, 255 sends all
    // pixels to the ramp.
    task automatic test_threshold_edges();
        set_config(8'd0, 8'd1, 8'd26);
        send_pixel(8'd100, 8'd100, 8'd100);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd200, 8'd200, 8'd199);
        repeat (20) send_random_pixel();
        wait_idle();
        set_config(8'd255, 8'd1, 8'd26);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd1,   8'd0, 8'd0);
        repeat (20) send_random_pixel();
        wait_idle();
    endtask

    // Grey-only mode across level counts, including ones that clamp and a
    // write whose upper bits fall outside the field.
    task automatic test_grey_levels();
        logic [7:0] counts [10];
        logic [7:0] v;
        counts = '{8'd2, 8'd3, 8'd13, 8'd25, 8'd26, 8'd0, 8'd1, 8'd27, 8'd31, 8'hE5};
        foreach (counts[k])
        begin
            set_config(8'($urandom_range(0, 255)), 8'd0, counts[k]);
            send_pixel(8'd0, 8'd0, 8'd0);
            send_pixel(8'd255, 8'd255, 8'd255);
            repeat (5)
            begin
                v = 8'($urandom_range(0, 255));
                send_pixel(v, v, v);
            end
            repeat (6) send_random_pixel();
            wait_idle();
        end
    endtask

    // A write past the register list must leave every setting alone.
    task automatic test_unused_index();
        set_config(8'd64, 8'd1, 8'd13);
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        write_reg(CFG_UNUSED, 8'hFF);
        repeat (20) send_random_pixel();
        wait_idle();
    endtask

    // Bulk random pixels over random register settings, extremes included.
    task automatic test_random_mix();
        logic [7:0] thr;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:       thr = 8'd0;
                1:       thr = 8'd255;
                default: thr = 8'($urandom_range(0, 255));
            endcase
            // Keep color mode on most of the time so the cube path gets traffic.
            set_config(thr, ($urandom_range(0, 3) != 0) ? 8'd1 : 8'd0,
                       8'($urandom_range(0, 255)));
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            repeat (105) send_random_pixel();
            wait_idle();
        end
    endtask

    // Back to defaults with no gaps or stalls: one pixel every cycle.
    task automatic test_full_rate();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        set_config(SAT_THRESH_RESET, {7'd0, COLOR_MODE_RESET}, {3'd0, GREY_LEVELS_RESET});
        repeat (100) send_random_pixel();
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_threshold_edges();
        test_grey_levels();
        test_unused_index();
        test_random_mix();
        test_full_rate();

        if (palette_fifo.size() != 0)
            report_failure($sformatf("%0d indexes never returned", palette_fifo.size()));

        if (errors == 0)
            $display("** rgb_to_xterm256_index: PASSED **");
        else
            $display("** rgb_to_xterm256_index: FAILED **");
        $finish;
    end

endmodule

// ===== rgb_to_xterm256_index.f =====
+incdir+src
src/rgb2xt_pkg.sv
src/rgb2xt_front.sv
src/rgb2xt_decide.sv
src/rgb2xt_map.sv
src/rgb_to_xterm256_index.sv
dv/tb.sv
